/* hdl/mgrt_pkg.sv */
`default_nettype none

package mgrt_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 64;
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned CAP_W           = 7;
  localparam int unsigned COUNT_OUT_W     = 7;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2
  } status_t;

  // Handed from each cell to its right neighbor.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               valid;
    logic               take;
  } link_t;

endpackage

`default_nettype wire

/* hdl/mgrt_cell.sv */
`default_nettype none

// One slot of the sorted chain. Values ascend from cell 0 to the right.
module mgrt_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               ins,
  input  wire logic [mgrt_pkg::VALUE_W-1:0]       new_value,
  input  wire mgrt_pkg::link_t                    left,
  output mgrt_pkg::link_t                         right,
  output logic [mgrt_pkg::VALUE_W-1:0]            gap,
  output logic                                    gap_ok,
  output logic                                    fresh
);

  logic [mgrt_pkg::VALUE_W-1:0] value;
  logic                         valid;
  logic                         take;

  // Empty slots and slots holding a larger value move right on insert.
  assign take = !valid || ($signed(value) > $signed(new_value));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      fresh <= 1'b0;
    end else if (ins) begin
      fresh <= take && !left.take;
      if (take) begin
        valid <= left.take ? left.valid : 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins && take) begin
      value <= left.take ? left.value : new_value;
    end
  end

  // Sorted order makes this difference exact and non-negative.
  assign gap    = value - left.value;
  assign gap_ok = valid && left.valid;

  assign right = '{value: value, valid: valid, take: take};

endmodule

`default_nettype wire

/* hdl/min_gap_and_range_tracker_core.sv */
`default_nettype none

// Query: result registered in the cycle after the input beat; one beat per cycle
//   while the output is not stalled. Add: result registered in the cycle after the
//   input beat; the next input beat waits while the gap state folds the new neighbor
//   gaps into the running minimum. Rejected adds do not enter the gap state.
// Reset (rst, synchronous): empties the chain, zeroes count/capacity, minimum all ones.
// Cell contents are not reset; only slots marked valid are ever used.
module min_gap_and_range_tracker_core #(
  parameter int unsigned MAX_ENTRIES = mgrt_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,   // capacity
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,     // value
  input  wire logic [0:0]  s_tuser,     // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,     // shortest_span, longest_span, entry_count, pad
  output logic [1:0]       m_tuser      // status
);

  localparam int unsigned VW = mgrt_pkg::VALUE_W;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LW = (CW > mgrt_pkg::CAP_W) ? CW : mgrt_pkg::CAP_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_GAP  = 2'b10
  } state_t;

  state_t                        state, state_next;
  logic [mgrt_pkg::CAP_W-1:0]    capacity;
  logic [CW-1:0]                 count;
  logic [VW-1:0]                 lo, hi, min_gap;
  logic                          accept, is_add, full, ins;
  logic [LW-1:0]                 count_w;
  logic [CW-1:0]                 count_inc;
  logic [LW-1:0]                 count_inc_w;

  mgrt_pkg::link_t               links [MAX_ENTRIES];
  logic [VW-1:0]                 gaps  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]        gap_ok, fresh, valid_vec;
  logic [VW-1:0]                 gap_l, gap_r, gap_min;

  logic                          out_valid;
  mgrt_pkg::status_t             out_status;
  logic [VW-1:0]                 out_short, out_long;
  logic [mgrt_pkg::COUNT_OUT_W-1:0] out_cnt;

  assign s_tready    = (state == S_IDLE) && (!out_valid || m_tready);
  assign accept      = s_tvalid && s_tready;
  assign is_add      = (mgrt_pkg::op_t'(s_tuser[0]) == mgrt_pkg::OP_ADD);
  assign count_w     = LW'(count);
  assign full        = (count_w >= LW'(capacity)) || (count_w >= LW'(MAX_ENTRIES));
  assign ins         = accept && is_add && !full;
  assign count_inc   = count + CW'(1);
  assign count_inc_w = LW'(count_inc);

  // Sorted insertion chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    mgrt_pkg::link_t left;
    if (i == 0) begin : g_head
      assign left = '{value: '0, valid: 1'b0, take: 1'b0};
    end else begin : g_body
      assign left = links[i-1];
    end
    mgrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ins       (ins),
      .new_value (s_tdata),
      .left      (left),
      .right     (links[i]),
      .gap       (gaps[i]),
      .gap_ok    (gap_ok[i]),
      .fresh     (fresh[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  // Gaps on both sides of the value just inserted; absent sides read as all ones.
  always_comb begin
    gap_l = '1;
    gap_r = '1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (fresh[i] && gap_ok[i]) begin
        gap_l = gap_l & gaps[i];
      end
      if (i > 0) begin
        if (fresh[i-1] && gap_ok[i]) begin
          gap_r = gap_r & gaps[i];
        end
      end
    end
    gap_min = min_gap;
    if (gap_l < gap_min) begin
      gap_min = gap_l;
    end
    if (gap_r < gap_min) begin
      gap_min = gap_r;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ins) begin
          state_next = S_GAP;
        end
      end
      S_GAP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= '0;
      count    <= '0;
      min_gap  <= '1;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (ins) begin
        count <= count_inc;
      end
      if (state == S_GAP) begin
        min_gap <= gap_min;
      end
    end
  end

  // Running extremes
  always_ff @(posedge clk) begin
    if (ins) begin
      if (count == '0 || $signed(s_tdata) < $signed(lo)) begin
        lo <= s_tdata;
      end
      if (count == '0 || $signed(s_tdata) > $signed(hi)) begin
        hi <= s_tdata;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_short <= '0;
      out_long  <= '0;
      out_cnt   <= count_w[mgrt_pkg::COUNT_OUT_W-1:0];
      if (is_add) begin
        if (full) begin
          out_status <= mgrt_pkg::ST_FULL;
        end else begin
          out_status <= mgrt_pkg::ST_OK;
          out_cnt    <= count_inc_w[mgrt_pkg::COUNT_OUT_W-1:0];
        end
      end else if (count < CW'(2)) begin
        out_status <= mgrt_pkg::ST_FEW;
      end else begin
        out_status <= mgrt_pkg::ST_OK;
        out_short  <= min_gap;
        out_long   <= hi - lo;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {1'b0, out_cnt, out_long, out_short};

  a_add_folds_gap : assert property (@(posedge clk) disable iff (rst)
    ins |=> (state == S_GAP))
    else $error("accepted add did not enter gap update");

  a_one_fresh : assert property (@(posedge clk) disable iff (rst)
    (state == S_GAP) |-> $onehot(fresh))
    else $error("gap update without exactly one new slot");

  a_count_matches_chain : assert property (@(posedge clk) disable iff (rst)
    count == CW'($countones(valid_vec)))
    else $error("count disagrees with occupied slots");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    LW'(count) <= LW'(MAX_ENTRIES))
    else $error("count above slot total");

  a_chain_packed : assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + {{(MAX_ENTRIES-1){1'b0}}, 1'b1}) & valid_vec) == '0)
    else $error("occupied slots not packed at the head");

endmodule

`default_nettype wire

/* verif/min_gap_and_range_tracker_core_test.sv */
`default_nettype none

module min_gap_and_range_tracker_core_test;

  localparam int unsigned STORE_DEPTH = mgrt_pkg::DEF_MAX_ENTRIES;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_PCT    = 21;

  typedef struct packed {
    mgrt_pkg::status_t status;
    logic [31:0]       shortest;
    logic [31:0]       longest;
    logic [6:0]        count;
  } span_result_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_FIXED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    mgrt_pkg::op_t   op;
    logic [31:0]     value;
    span_result_t    res;
  } row_t;

  typedef enum logic [1:0] {
    VAL_WIDE,
    VAL_CLUSTER,
    VAL_MIXED
  } value_mode_t;

  typedef struct packed {
    logic [6:0]  cap;
    value_mode_t mode;
    int unsigned items;
    int unsigned add_pct;
  } phase_t;

  localparam span_result_t NO_RES = '{mgrt_pkg::ST_OK, 32'h0, 32'h0, 7'd0};

  // Directed part. Cfg rows carry the capacity in value.
  localparam int unsigned PLAN_LEN = 21;
  localparam row_t PLAN [PLAN_LEN] = '{
    '{ROW_FIXED,   mgrt_pkg::OP_QUERY, 32'h0000_0000,
      '{mgrt_pkg::ST_FEW,  32'h0, 32'h0, 7'd0}},
    '{ROW_FIXED,   mgrt_pkg::OP_ADD,   32'h0000_0005,
      '{mgrt_pkg::ST_FULL, 32'h0, 32'h0, 7'd0}},
    '{ROW_CFG,     mgrt_pkg::OP_ADD,   32'h0000_007F, NO_RES},
    '{ROW_FIXED,   mgrt_pkg::OP_QUERY, 32'hFFFF_FFFF,
      '{mgrt_pkg::ST_FEW,  32'h0, 32'h0, 7'd0}},
    '{ROW_FIXED,   mgrt_pkg::OP_ADD,   32'h7FFF_FFFF,
      '{mgrt_pkg::ST_OK,   32'h0, 32'h0, 7'd1}},
    '{ROW_FIXED,   mgrt_pkg::OP_QUERY, 32'h0000_0000,
      '{mgrt_pkg::ST_FEW,  32'h0, 32'h0, 7'd1}},
    '{ROW_FIXED,   mgrt_pkg::OP_ADD,   32'h8000_0000,
      '{mgrt_pkg::ST_OK,   32'h0, 32'h0, 7'd2}},
    '{ROW_FIXED,   mgrt_pkg::OP_QUERY, 32'h1234_5678,
      '{mgrt_pkg::ST_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd2}},
    '{ROW_FIXED,   mgrt_pkg::OP_ADD,   32'h0000_0000,
      '{mgrt_pkg::ST_OK,   32'h0, 32'h0, 7'd3}},
    '{ROW_PREDICT, mgrt_pkg::OP_QUERY, 32'h0000_0000, NO_RES},
    '{ROW_PREDICT, mgrt_pkg::OP_ADD,   32'h4000_0000, NO_RES},
    '{ROW_PREDICT, mgrt_pkg::OP_QUERY, 32'h8000_0000, NO_RES},
    // capacity below the stored count
    '{ROW_CFG,     mgrt_pkg::OP_ADD,   32'h0000_0002, NO_RES},
    '{ROW_FIXED,   mgrt_pkg::OP_ADD,   32'h0000_0001,
      '{mgrt_pkg::ST_FULL, 32'h0, 32'h0, 7'd4}},
    '{ROW_PREDICT, mgrt_pkg::OP_QUERY, 32'h0000_0000, NO_RES},
    '{ROW_CFG,     mgrt_pkg::OP_ADD,   32'h0000_0004, NO_RES},
    '{ROW_FIXED,   mgrt_pkg::OP_ADD,   32'hFFFF_FFFB,
      '{mgrt_pkg::ST_FULL, 32'h0, 32'h0, 7'd4}},
    '{ROW_CFG,     mgrt_pkg::OP_ADD,   32'h0000_0005, NO_RES},
    '{ROW_PREDICT, mgrt_pkg::OP_ADD,   32'hC000_0000, NO_RES},
    '{ROW_FIXED,   mgrt_pkg::OP_ADD,   32'h0000_0001,
      '{mgrt_pkg::ST_FULL, 32'h0, 32'h0, 7'd5}},
    '{ROW_PREDICT, mgrt_pkg::OP_QUERY, 32'h7FFF_FFFF, NO_RES}
  };

  // The store only grows, while the phases move the capacity both up and down.
  localparam int unsigned PHASE_CNT = 8;
  localparam phase_t PHASES [PHASE_CNT] = '{
    '{7'd0,   VAL_WIDE,    120, 70},
    '{7'd12,  VAL_WIDE,    230, 50},
    '{7'd3,   VAL_WIDE,    150, 60},
    '{7'd30,  VAL_CLUSTER, 250, 40},
    '{7'd64,  VAL_MIXED,   330, 30},
    '{7'd127, VAL_MIXED,   250, 40},
    '{7'd65,  VAL_MIXED,   200, 50},
    '{7'd64,  VAL_MIXED,   200, 50}
  };
  localparam int unsigned HOLD_PHASE = 3;
  localparam int unsigned CALM_PHASE = 5;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;

  min_gap_and_range_tracker_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Own copy of the store
  logic signed [31:0] held_vals [STORE_DEPTH];
  int unsigned        held_count;
  logic [6:0]         held_cap;

  span_result_t pending_spans [$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  logic         calm = 1'b0;
  logic [7:0]   hold_req = '0;
  logic [7:0]   hold_ack = '0;
  int unsigned  hold_left = 0;

  function automatic span_result_t track_spans(mgrt_pkg::op_t op, logic [31:0] value);
    span_result_t       r;
    int unsigned        limit;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [31:0]        d;
    r = NO_RES;
    limit = (held_cap > STORE_DEPTH) ? STORE_DEPTH : held_cap;
    if (op == mgrt_pkg::OP_ADD) begin
      if (held_count >= limit) begin
        r.status = mgrt_pkg::ST_FULL;
      end else begin
        held_vals[held_count] = value;
        held_count++;
      end
    end else if (held_count < 2) begin
      r.status = mgrt_pkg::ST_FEW;
    end else begin
      lo = held_vals[0];
      hi = held_vals[0];
      r.shortest = '1;
      for (int unsigned i = 0; i < held_count; i++) begin
        if (held_vals[i] < lo) lo = held_vals[i];
        if (held_vals[i] > hi) hi = held_vals[i];
        for (int unsigned j = i + 1; j < held_count; j++) begin
          if (held_vals[i] >= held_vals[j]) d = held_vals[i] - held_vals[j];
          else d = held_vals[j] - held_vals[i];
          if (d < r.shortest) r.shortest = d;
        end
      end
      r.longest = hi - lo;
    end
    r.count = held_count[6:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_value(value_mode_t mode, logic [31:0] base);
    logic [31:0] v;
    v = $urandom;
    if (mode == VAL_CLUSTER) begin
      v = base + $urandom_range(0, 65536) - 32768;
    end else if (mode == VAL_MIXED && held_count > 0) begin
      case ($urandom_range(0, 4))
        1: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        2: v = held_vals[$urandom_range(0, held_count - 1)];
        3: v = held_vals[$urandom_range(0, held_count - 1)] + $urandom_range(1, 7);
        4: v = $urandom_range(0, 64) - 32;
        default: v = $urandom;
      endcase
    end
    return v;
  endfunction

  task automatic send_beat(mgrt_pkg::op_t op, logic [31:0] value, bit typed,
                           span_result_t typed_res);
    span_result_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = track_spans(op, value);
    pending_spans = {pending_spans, (typed ? typed_res : r)};
  endtask

  // Capacity is only touched with the block idle; the extra cycles cover the
  // gap fold that follows an add.
  task automatic write_capacity(logic [6:0] cap);
    s_tvalid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    held_cap = cap;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result side: checks beats, then drives tready for the next edge.
  always @(posedge clk) begin : result_side
    span_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_spans.size() == 0) begin
        $display("%0t: unexpected result beat, expected none got status %0d data %h",
                 $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending_spans.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("shortest_span", want.shortest, m_tdata[31:0]);
        check_field("longest_span", want.longest, m_tdata[63:32]);
        check_field("entry_count", 32'(want.count), 32'(m_tdata[70:64]));
      end
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("min_gap_and_range_tracker_core_test failed");
      $finish;
    end
  end

  initial begin
    logic [31:0]   base;
    logic [31:0]   v;
    mgrt_pkg::op_t op;
    held_count = 0;
    held_cap   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int unsigned k = 0; k < PLAN_LEN; k++) begin
      if (PLAN[k].kind == ROW_CFG) write_capacity(PLAN[k].value[6:0]);
      else send_beat(PLAN[k].op, PLAN[k].value, PLAN[k].kind == ROW_FIXED, PLAN[k].res);
    end

    for (int unsigned p = 0; p < PHASE_CNT; p++) begin
      write_capacity(PHASES[p].cap);
      calm <= (p == CALM_PHASE);
      base = $urandom;
      for (int unsigned n = 0; n < PHASES[p].items; n++) begin
        // long receiver stall while the sender keeps offering beats
        if (p == HOLD_PHASE && n == 20) hold_req <= hold_req + 1;
        op = ($urandom_range(0, 99) < PHASES[p].add_pct) ? mgrt_pkg::OP_ADD
                                                          : mgrt_pkg::OP_QUERY;
        v  = (op == mgrt_pkg::OP_ADD) ? pick_value(PHASES[p].mode, base) : $urandom;
        send_beat(op, v, 1'b0, NO_RES);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("min_gap_and_range_tracker_core_test passed");
    end else begin
      $display("min_gap_and_range_tracker_core_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
